@@ rtl/mrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrs_pkg: shared definitions for the Morton rectangle scanner
// Widths, register indexes and the bit interleave helpers used by the
// scanner core and its next-cell search.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // largest rectangle side; local coordinates stay below it
  localparam int MaxSide = 1024;
  localparam int CoordW  = $clog2(MaxSide);
  localparam int MortW   = 2 * CoordW;

  // fixed field widths
  localparam int LenW    = 11;
  localparam int PointW  = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegYOffset = 2'd0,
    RegZOffset = 2'd1,
    RegYLength = 2'd2,
    RegZLength = 2'd3
  } mrs_reg_e;

  // interleave y into even bits and z into odd bits
  function automatic logic [MortW-1:0] mrs_interleave(logic [CoordW-1:0] y,
                                                      logic [CoordW-1:0] z);
    logic [MortW-1:0] r;
    r = '0;
    for (int i = 0; i < CoordW; i++) begin
      r[2*i]   = y[i];
      r[2*i+1] = z[i];
    end
    return r;
  endfunction

  // pull one coordinate back out of an index (lane 0 is y, lane 1 is z)
  function automatic logic [CoordW-1:0] mrs_gather(logic [MortW-1:0] m, logic lane);
    logic [CoordW-1:0] r;
    r = '0;
    for (int i = 0; i < CoordW; i++) begin
      r[i] = lane ? m[2*i+1] : m[2*i];
    end
    return r;
  endfunction

endpackage

@@ rtl/morton_rectangle_scan.sv @@
// ----------------------------------------------------------------------------
// morton_rectangle_scan: Z-order address generator for a rectangle
// Visits every cell of a y_length by z_length rectangle in Morton order
// (y is the fast direction) and emits offset plus local coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes y_offset, z_offset, y_length, z_length by index; it is
//   always ready and should be used only while no request is in flight.
//   Each slave beat is one request (tdata bit 0 = restart); each request gives
//   exactly one master beat carrying the point and tlast on the final cell.
//   A request after the final cell, or with restart set, gives the first cell.
// Timing:
//   two register stages (request register, result register): each request
//   is held in both in turn. One request per cycle is sustained while the
//   master side does not stall; the next cell search is combinational on
//   the stored Morton position, so back-to-back requests run at full rate.
// Reset:
//   registers return to offsets 0 and lengths 1, the scan is marked fresh.
// Stall:
//   a held result stalls the request stage; one more request is still taken
//   into the request register before tready drops.
// ----------------------------------------------------------------------------
module morton_rectangle_scan
  import mrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [0] restart, [7:1] zero
  // point stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*PointW-1:0] m_axis_tdata,   // [31:0] point_y, [63:32] point_z
  output logic                m_axis_tlast    // is_last
);

  // configuration registers
  logic [PointW-1:0] y_offset_q, z_offset_q;
  logic [LenW-1:0]   y_length_q, z_length_q;

  // request stage
  logic in_valid_q, in_valid_d;
  logic restart_q;

  // scan state
  logic [MortW-1:0] pos_q, pos_d;
  logic             fresh_q, fresh_d;

  // result stage
  logic              out_valid_q, out_valid_d;
  logic [PointW-1:0] point_y_q, point_y_d;
  logic [PointW-1:0] point_z_q, point_z_d;
  logic              last_q, last_d;

  logic              out_free;
  logic              adv;
  logic              in_acc;
  logic [CoordW-1:0] y_max, z_max;
  logic [MortW-1:0]  last_pos;
  logic [MortW-1:0]  next_pos;
  logic [MortW-1:0]  sel_pos;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_offset_q <= '0;
      z_offset_q <= '0;
      y_length_q <= LenW'(1);
      z_length_q <= LenW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mrs_reg_e'(cfg_index_i))
        RegYOffset: y_offset_q <= cfg_data_i;
        RegZOffset: z_offset_q <= cfg_data_i;
        RegYLength: y_length_q <= cfg_data_i[LenW-1:0];
        RegZLength: z_length_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // effective maximum local coordinate, length clamped to 1..MaxSide
  always_comb begin
    if (y_length_q == '0) begin
      y_max = '0;
    end else if (32'(y_length_q) > 32'(MaxSide)) begin
      y_max = CoordW'(MaxSide - 1);
    end else begin
      y_max = CoordW'(y_length_q - LenW'(1));
    end
    if (z_length_q == '0) begin
      z_max = '0;
    end else if (32'(z_length_q) > 32'(MaxSide)) begin
      z_max = CoordW'(MaxSide - 1);
    end else begin
      z_max = CoordW'(z_length_q - LenW'(1));
    end
  end

  assign last_pos = mrs_interleave(y_max, z_max);

  // next cell search
  mrs_next u_next (
    .pos_i   (pos_q),
    .y_max_i (y_max),
    .z_max_i (z_max),
    .next_o  (next_pos)
  );

  // position chosen for the request at the head of the pipe
  always_comb begin
    if (restart_q || fresh_q || pos_q >= last_pos) begin
      sel_pos = '0;
    end else begin
      sel_pos = next_pos;
    end
  end

  // next values for state and result
  always_comb begin
    in_valid_d  = in_valid_q;
    pos_d       = pos_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q;
    point_y_d   = point_y_q;
    point_z_d   = point_z_q;
    last_d      = last_q;
    if (out_free) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      in_valid_d  = 1'b0;
      pos_d       = sel_pos;
      fresh_d     = 1'b0;
      out_valid_d = 1'b1;
      point_y_d   = y_offset_q + PointW'(mrs_gather(sel_pos, 1'b0));
      point_z_d   = z_offset_q + PointW'(mrs_gather(sel_pos, 1'b1));
      last_d      = (sel_pos == last_pos);
    end
    if (in_acc) begin
      in_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      fresh_q     <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      fresh_q     <= fresh_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      restart_q <= s_axis_tdata[0];
    end
    point_y_q <= point_y_d;
    point_z_q <= point_z_d;
    last_q    <= last_d;
  end

  // outputs
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {point_z_q, point_y_q};
  assign m_axis_tlast  = last_q;

endmodule

@@ rtl/mrs_next.sv @@
// ----------------------------------------------------------------------------
// mrs_next: next in-range Morton index
// For every zero bit k of the current index the aligned block that starts by
// setting bit k and clearing the bits below is a candidate; its first cell is
// inside the rectangle exactly when the block holds any inside cell. The
// lowest such k gives the next index.
// ----------------------------------------------------------------------------
module mrs_next
  import mrs_pkg::*;
(
  input  logic [MortW-1:0]  pos_i,
  input  logic [CoordW-1:0] y_max_i,
  input  logic [CoordW-1:0] z_max_i,
  output logic [MortW-1:0]  next_o
);

  logic [MortW-1:0] cand  [MortW];
  logic [MortW-1:0] hit;

  // one candidate block per bit position
  always_comb begin
    logic [MortW-1:0] bit_k;
    for (int k = 0; k < MortW; k++) begin
      bit_k   = MortW'(1) << k;
      cand[k] = (pos_i | bit_k) & ~(bit_k - MortW'(1));
      hit[k]  = !pos_i[k] &&
                (mrs_gather(cand[k], 1'b0) <= y_max_i) &&
                (mrs_gather(cand[k], 1'b1) <= z_max_i);
    end
  end

  // lowest hitting position wins
  always_comb begin
    next_o = '0;
    for (int k = MortW - 1; k >= 0; k--) begin
      if (hit[k]) begin
        next_o = cand[k];
      end
    end
  end

endmodule

@@ tb/sv/mrs_scan_checker.sv @@
// ----------------------------------------------------------------------------
// mrs_scan_checker: point stream checker for the Morton rectangle scanner
// Watches the config, request and point channels. Keeps its own copy of the
// registers and scan position, predicts the point for every accepted request
// and compares each point beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module mrs_scan_checker
  import mrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [7:0]          req_data_i,     // [0] restart, [7:1] zero
  input  logic                pt_valid_i,
  input  logic                pt_ready_i,
  input  logic [2*PointW-1:0] pt_data_i,      // [31:0] point_y, [63:32] point_z
  input  logic                pt_last_i,      // is_last
  output int unsigned         mismatch_count_o,
  output int unsigned         outstanding_o
);

  typedef struct packed {
    logic [PointW-1:0] y;
    logic [PointW-1:0] z;
    logic              last;
  } point_t;

  // shadow registers and scan state
  logic [PointW-1:0] y_origin = '0;
  logic [PointW-1:0] z_origin = '0;
  logic [LenW-1:0]   y_extent = LenW'(1);
  logic [LenW-1:0]   z_extent = LenW'(1);
  logic [MortW-1:0]  scan_pos = '0;
  logic              scan_fresh = 1'b1;

  point_t      pending_points[$];
  int unsigned mismatch_total = 0;

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_total < 40) $display("[%0t] point check: %s", $time, msg);
    mismatch_total++;
  endtask

  // zero counts as one, anything above the side saturates
  function automatic logic [15:0] clamp_len(input logic [LenW-1:0] v);
    if (v == '0) return 16'd1;
    if (v > LenW'(MaxSide)) return 16'(MaxSide);
    return 16'(v);
  endfunction

  function automatic logic [63:0] spread_coord(input logic [15:0] v);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) r[2*i] = v[i];
    return r;
  endfunction

  function automatic logic [15:0] gather_coord(input logic [63:0] m, input int lane);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = m[2*i+lane];
    return r;
  endfunction

  // smallest in-rectangle index above m, skipping aligned blocks outside
  function automatic logic [63:0] next_cell_index(input logic [63:0] m,
                                                  input logic [15:0] yl,
                                                  input logic [15:0] zl);
    logic [63:0] k;
    logic [15:0] cy, cz;
    int          j;
    logic        found;
    k = m + 64'd1;
    found = 1'b0;
    while (!found) begin
      cy = gather_coord(k, 0);
      cz = gather_coord(k, 1);
      if (cy < yl && cz < zl) begin
        found = 1'b1;
      end else begin
        j = 15;
        while (j > 0 && ((cy >> j) << j) < yl && ((cz >> j) << j) < zl) j--;
        k = ((k >> (2*j)) + 64'd1) << (2*j);
      end
    end
    return k;
  endfunction

  // one request: advance the scan and form the point
  function automatic point_t advance_scan(input logic restart);
    logic [15:0] yl, zl;
    logic [63:0] final_idx, idx;
    point_t      p;
    yl = clamp_len(y_extent);
    zl = clamp_len(z_extent);
    final_idx = spread_coord(yl - 16'd1) | (spread_coord(zl - 16'd1) << 1);
    if (restart || scan_fresh || 64'(scan_pos) >= final_idx) idx = '0;
    else idx = next_cell_index(64'(scan_pos), yl, zl);
    scan_pos   = idx[MortW-1:0];
    scan_fresh = 1'b0;
    p.y    = y_origin + PointW'(gather_coord(idx, 0));
    p.z    = z_origin + PointW'(gather_coord(idx, 1));
    p.last = (idx == final_idx);
    return p;
  endfunction

  // compare points, then track config writes and requests
  always @(posedge clk_i or negedge rst_ni) begin
    point_t got, want;
    if (!rst_ni) begin
      y_origin   = '0;
      z_origin   = '0;
      y_extent   = LenW'(1);
      z_extent   = LenW'(1);
      scan_pos   = '0;
      scan_fresh = 1'b1;
      pending_points.delete();
    end else begin
      if (pt_valid_i && pt_ready_i) begin
        got.y    = pt_data_i[PointW-1:0];
        got.z    = pt_data_i[2*PointW-1:PointW];
        got.last = pt_last_i;
        if (pending_points.size() == 0) begin
          report_mismatch($sformatf("point beat y=%h z=%h with no request waiting",
                                    got.y, got.z));
        end else begin
          want = pending_points.pop_front();
          if (got.y !== want.y)
            report_mismatch($sformatf("point_y %h, predicted %h", got.y, want.y));
          if (got.z !== want.z)
            report_mismatch($sformatf("point_z %h, predicted %h", got.z, want.z));
          if (got.last !== want.last)
            report_mismatch($sformatf("is_last %b, predicted %b at y=%h z=%h",
                                      got.last, want.last, want.y, want.z));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegYOffset: y_origin = cfg_data_i;
          RegZOffset: z_origin = cfg_data_i;
          RegYLength: y_extent = cfg_data_i[LenW-1:0];
          RegZLength: z_extent = cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i)
        pending_points = {pending_points, advance_scan(req_data_i[0])};
    end
    mismatch_count_o <= mismatch_total;
    outstanding_o    <= pending_points.size();
  end

endmodule

@@ tb/sv/tb_morton_rectangle_scan.sv @@
// ----------------------------------------------------------------------------
// tb_morton_rectangle_scan: testbench top for the Morton rectangle scanner
// Drives config writes and scan requests with random gaps and back-pressure,
// runs directed corner cases then randomized rectangles, and reports the
// verdict from the mismatch count of the point checker.
// ----------------------------------------------------------------------------
module tb_morton_rectangle_scan;
  import mrs_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDatW-1:0]  cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [0] restart, [7:1] zero
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [2*PointW-1:0] m_axis_tdata;   // [31:0] point_y, [63:32] point_z
  logic                m_axis_tlast;   // is_last

  int unsigned mismatch_count;
  int unsigned outstanding;

  // traffic shaping knobs shared by the sender and receiver
  bit          tx_gaps_on = 1'b0;
  bit          rx_gaps_on = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned requests_sent = 0;

  morton_rectangle_scan DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  mrs_scan_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_i      (s_axis_tready),
    .req_data_i       (s_axis_tdata),
    .pt_valid_i       (m_axis_tvalid),
    .pt_ready_i       (m_axis_tready),
    .pt_data_i        (m_axis_tdata),
    .pt_last_i        (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // run limit
  initial begin
    #4000000;
    $display("timeout: scanner stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // point receiver: random stall bursts, one long hold-off on request
  initial m_axis_tready <= 1'b0;
  always begin
    @(posedge clk_i);
    if (hold_request) begin
      m_axis_tready <= 1'b0;
      repeat (80) @(posedge clk_i);
      hold_request = 1'b0;
      m_axis_tready <= 1'b1;
    end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(input mrs_reg_e idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // one request beat, optionally preceded by an idle burst
  task automatic send_request(input logic restart);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // drop valid and let every point drain before touching registers
  task automatic drain_scan();
    s_axis_tvalid <= 1'b0;
    // the checker count is registered, so let it take in the last beat
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random register value: offsets often near wrap, lengths mostly small
  function automatic logic [CfgDatW-1:0] pick_reg_value(input mrs_reg_e idx);
    int unsigned      r;
    logic [LenW-1:0]  v;
    logic [CfgDatW-1:0] junk;
    r    = $urandom_range(0, 99);
    junk = $urandom();
    if (idx == RegYOffset || idx == RegZOffset) begin
      if (r < 20) return 32'hFFFF_FFFF - $urandom_range(0, 20);
      if (r < 30) return 32'(r);
      return junk;
    end
    if (r < 6) v = '0;
    else if (r < 12) v = LenW'(MaxSide + $urandom_range(1, 1023));
    else if (r < 15) v = LenW'(MaxSide);
    else if (r < 25) v = LenW'($urandom_range(25, 64));
    else v = LenW'($urandom_range(1, 24));
    return {junk[CfgDatW-1:LenW], v};
  endfunction

  initial begin
    mrs_reg_e    idx;
    int unsigned phase_no;
    int unsigned beats;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= RegYOffset;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset rectangle is one cell, every request is the last cell
    repeat (2) send_request(1'b0);
    drain_scan();

    // 3 by 2 with offsets that wrap, restart mid-scan, run past the end
    write_reg(RegYOffset, 32'hFFFF_FFFF);
    write_reg(RegZOffset, 32'hFFFF_FFFE);
    write_reg(RegYLength, 32'd3);
    write_reg(RegZLength, 32'd2);
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    repeat (7) send_request(1'b0);
    drain_scan();

    // zero length reads as one, oversize length saturates
    write_reg(RegYLength, 32'hFFFF_F800);
    write_reg(RegZLength, 32'h0000_07FF);
    repeat (3) send_request(1'b0);
    drain_scan();

    // lengths changed mid-scan, scan continues from stored position
    write_reg(RegYLength, 32'd1024);
    write_reg(RegZLength, 32'd1);
    repeat (3) send_request(1'b0);
    drain_scan();

    // full square at origin
    write_reg(RegYOffset, 32'd0);
    write_reg(RegZOffset, 32'd0);
    write_reg(RegZLength, 32'd1024);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain_scan();

    // randomized rectangles
    phase_no = 0;
    while (requests_sent < 870) begin
      tx_gaps_on = (requests_sent < 700) && ($urandom_range(0, 3) != 0);
      rx_gaps_on = (requests_sent < 700) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 4; k++) begin
        idx = mrs_reg_e'(k);
        if ($urandom_range(0, 1) == 1) write_reg(idx, pick_reg_value(idx));
      end
      beats = $urandom_range(10, 45);
      // stall the point side long enough to back up the request side
      if (phase_no == 3) begin
        tx_gaps_on   = 1'b0;
        hold_request = 1'b1;
        beats        = 40;
      end
      repeat (beats) send_request($urandom_range(0, 15) == 0);
      drain_scan();
      phase_no++;
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
